// ===== rtl/core/asr_env_pkg.sv =====
// Shared types and constants for the ASR envelope generator.
`timescale 1ns / 1ps

package asr_env_pkg;

    // Envelope phase, also carried on the result tuser
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ATTACK_STEP  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_RELEASE_STEP = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_SUSTAIN_LVL  = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_TRIG_THRESH  = t_cfg_idx'(3);

endpackage

// ===== rtl/core/asr_envelope_generator_top.sv =====
// Top level of the ASR envelope generator: stream ports, config registers, pipeline.
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+-------------------------------
//  s (in)    | slave     | i_s_tvalid / o_s_tready     | tdata: trigger_level (signed)
//  m (out)   | master    | o_m_tvalid / i_m_tready     | tdata: envelope_value,
//            |           |                             | tuser: env_phase
//  cfg       | slave     | i_cfg_valid / o_cfg_ready   | index, data
//
//  One request per cycle sustained while results are taken; a request passes the input
//  register, then the result register (the envelope state updates with the result).
//  Reset (synchronous, active low) empties both stages, loads the default registers,
//  and leaves the envelope in attack at level 0.
//  A stalled result holds the result register; the input register still takes one
//  request, then input ready drops until the result is taken.
`timescale 1ns / 1ps

module asr_envelope_generator_top #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      i_s_tdata,   // [SB-1:0] trigger_level
    // output stream
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      o_m_tdata,   // [SB-1:0] envelope_value
    output logic [1:0]                            o_m_tuser,   // [1:0] env_phase
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  asr_env_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [SAMPLE_BITS-1:0]                i_cfg_data
);

    localparam int unsigned DataW = ((SAMPLE_BITS + 7) / 8) * 8;

    // configuration registers
    logic [SAMPLE_BITS-1:0]        r_attack_step;
    logic [SAMPLE_BITS-1:0]        r_release_step;
    logic [SAMPLE_BITS-1:0]        r_sustain_level;
    logic signed [SAMPLE_BITS-1:0] r_threshold;

    // envelope state
    asr_env_pkg::t_phase           r_phase;
    logic [SAMPLE_BITS-1:0]        r_level;
    logic signed [SAMPLE_BITS-1:0] r_last_trig;

    // pipeline stages
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_trig;
    logic                          r_out_valid;
    logic [SAMPLE_BITS-1:0]        r_out_level;
    asr_env_pkg::t_phase           r_out_phase;

    asr_env_pkg::t_phase           n_phase;
    logic [SAMPLE_BITS-1:0]        n_level;
    logic                          advance;
    logic                          in_take;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_step   <= SAMPLE_BITS'(68);
            r_release_step  <= SAMPLE_BITS'(1);
            r_sustain_level <= SAMPLE_BITS'(26214);
            r_threshold     <= SAMPLE_BITS'(16384);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                asr_env_pkg::CFG_ATTACK_STEP:  r_attack_step   <= i_cfg_data;
                asr_env_pkg::CFG_RELEASE_STEP: r_release_step  <= i_cfg_data;
                asr_env_pkg::CFG_SUSTAIN_LVL:  r_sustain_level <= i_cfg_data;
                asr_env_pkg::CFG_TRIG_THRESH:  r_threshold     <= i_cfg_data;
                default: ; // drop writes to unknown registers
            endcase
        end
    end

    // Move the input request to the result stage when the result register is free
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_trig <= i_s_tdata[SAMPLE_BITS-1:0];
        end
    end

    asr_env_step #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_step (
        .i_phase        (r_phase),
        .i_level        (r_level),
        .i_last_trig    (r_last_trig),
        .i_trig         (r_in_trig),
        .i_attack_step  (r_attack_step),
        .i_release_step (r_release_step),
        .i_sustain_level(r_sustain_level),
        .i_threshold    (r_threshold),
        .o_phase        (n_phase),
        .o_level        (n_level)
    );

    // Update envelope state once per advanced request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= asr_env_pkg::PH_ATTACK;
            r_level     <= '0;
            r_last_trig <= '0;
        end else if (advance) begin
            r_phase     <= n_phase;
            r_level     <= n_level;
            r_last_trig <= r_in_trig;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_level <= n_level;
            r_out_phase <= n_phase;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = DataW'(r_out_level);
    assign o_m_tuser  = r_out_phase;

endmodule

// ===== rtl/core/asr_env_step.sv =====
// Next-state logic of the envelope: edge detection, phase transition, level update.
`timescale 1ns / 1ps

module asr_env_step #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  asr_env_pkg::t_phase           i_phase,
    input  logic [SAMPLE_BITS-1:0]        i_level,
    input  logic signed [SAMPLE_BITS-1:0] i_last_trig,
    input  logic signed [SAMPLE_BITS-1:0] i_trig,
    input  logic [SAMPLE_BITS-1:0]        i_attack_step,
    input  logic [SAMPLE_BITS-1:0]        i_release_step,
    input  logic [SAMPLE_BITS-1:0]        i_sustain_level,
    input  logic signed [SAMPLE_BITS-1:0] i_threshold,
    output asr_env_pkg::t_phase           o_phase,
    output logic [SAMPLE_BITS-1:0]        o_level
);

    localparam logic [SAMPLE_BITS-1:0] LevelOne = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                   now_ge;
    logic                   before_ge;
    asr_env_pkg::t_phase    edge_phase;
    logic [SAMPLE_BITS:0]   attack_sum;

    // Detect threshold crossings between the previous and current trigger
    assign now_ge    = (i_trig >= i_threshold);
    assign before_ge = (i_last_trig >= i_threshold);

    always_comb begin
        if (now_ge && !before_ge) begin
            edge_phase = asr_env_pkg::PH_ATTACK;
        end else if (!now_ge && before_ge) begin
            edge_phase = asr_env_pkg::PH_RELEASE;
        end else begin
            edge_phase = i_phase;
        end
    end

    assign attack_sum = {1'b0, i_level} + {1'b0, i_attack_step};

    // Advance the level within the selected phase
    always_comb begin
        o_phase = edge_phase;
        o_level = i_level;
        case (edge_phase)
            asr_env_pkg::PH_ATTACK: begin
                if (attack_sum >= {1'b0, LevelOne}) begin
                    o_level = LevelOne;
                    o_phase = asr_env_pkg::PH_SUSTAIN;
                end else begin
                    o_level = attack_sum[SAMPLE_BITS-1:0];
                end
            end
            asr_env_pkg::PH_SUSTAIN: begin
                // saturate a sustain level above one
                o_level = (i_sustain_level > LevelOne) ? LevelOne : i_sustain_level;
            end
            asr_env_pkg::PH_RELEASE: begin
                if (i_release_step >= i_level) begin
                    o_level = '0;
                    o_phase = asr_env_pkg::PH_IDLE;
                end else begin
                    o_level = i_level - i_release_step;
                end
            end
            default: begin
                o_level = '0;
                o_phase = asr_env_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/asr_env_chk.sv =====
// Port-level checker for the ASR envelope generator, bound to the top level.
`timescale 1ns / 1ps

module asr_env_chk #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]  o_m_tdata,
    input logic [1:0]                        o_m_tuser
);

    localparam logic [SAMPLE_BITS-1:0] LevelOne = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        (!$past(i_rst_n) && i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

    // Envelope never exceeds one
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[SAMPLE_BITS-1:0] <= LevelOne))
        else $error("envelope above 1.0");

    // Idle phase always shows zero level
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == asr_env_pkg::PH_IDLE)
            |-> (o_m_tdata[SAMPLE_BITS-1:0] == '0))
        else $error("idle phase with nonzero envelope");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready)
            |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind asr_envelope_generator_top asr_env_chk #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_asr_env_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser)
);
